### hdl/julia_pkg.sv
// Shared types, widths and constants of the Julia escape-time pixel block.
package julia_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 28;
    localparam int STEP_W      = 31;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 10;
    localparam int ADDR_W      = 20;
    localparam int COLOR_W     = 24;
    localparam int BYTE_W      = 8;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SQ_W        = PROD_W - FRAC_BITS;
    localparam int SUM_W       = SQ_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_BITS    = ADDR_W + COLOR_W + CNT_W;
    localparam int OUT_DATA_W  = 56;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_BITS;
    localparam int DEF_IMAGE_SIDE = 1024;

    // Escape radius squared, 4.0 in the fixed-point format.
    localparam logic signed [SUM_W-1:0] ESCAPE_BOUND = SUM_W'(1) << (FRAC_BITS + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_REAL        = 3'd0,
        REG_C_IMAG        = 3'd1,
        REG_PIXEL_STEP    = 3'd2,
        REG_OFFSET_X      = 3'd3,
        REG_OFFSET_Y      = 3'd4,
        REG_ITER_LIMIT    = 3'd5,
        REG_COLOR_FACTORS = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic [STEP_W-1:0]         pixel_step;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic [CNT_W-1:0]          iter_limit;
        logic [COLOR_W-1:0]        color_factors;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        c_real:        32'sd76503450,
        c_imag:        32'sd2684355,
        pixel_step:    31'd671089,
        offset_x:      32'sd0,
        offset_y:      32'sd0,
        iter_limit:    10'd150,
        color_factors: 24'd0
    };

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic [CNT_W-1:0]   iter_count;
        logic               in_set;
    } result_t;

endpackage

### hdl/julia_mul.sv
// Shared signed 32 by 32 multiplier of the iteration datapath.
module julia_mul
(
    input  logic signed [julia_pkg::COORD_W-1:0] a,
    input  logic signed [julia_pkg::COORD_W-1:0] b,
    output logic signed [julia_pkg::PROD_W-1:0]  p
);
    import julia_pkg::*;

    assign p = PROD_W'(a) * PROD_W'(b);

endmodule

### hdl/julia_color.sv
// Colour mapping from iteration count to a packed RGB word.
module julia_color
(
    input  logic [julia_pkg::CNT_W-1:0]   iter_count,
    input  logic                          in_set,
    input  logic [julia_pkg::COLOR_W-1:0] color_factors,
    output logic [julia_pkg::COLOR_W-1:0] pixel_color
);
    import julia_pkg::*;

    localparam int NUM_CH = COLOR_W / BYTE_W;

    always_comb
    begin
        logic [2*BYTE_W-1:0] ch_prod;
        pixel_color = '0;
        ch_prod     = '0;
        // Only the low byte of each product survives, so the low byte of the count is enough.
        for (int i = 0; i < NUM_CH; i++)
        begin
            ch_prod = (2*BYTE_W)'(iter_count[BYTE_W-1:0])
                    * (2*BYTE_W)'(color_factors[i*BYTE_W +: BYTE_W]);
            pixel_color[i*BYTE_W +: BYTE_W] = in_set ? '0 : ch_prod[BYTE_W-1:0];
        end
    end

endmodule

### hdl/julia_core.sv
// Sequencer and iteration datapath around the shared multiplier.
module julia_core
#(
    parameter int IMAGE_SIDE = julia_pkg::DEF_IMAGE_SIDE
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [julia_pkg::IDX_W-1:0] in_column,
    input  logic [julia_pkg::IDX_W-1:0] in_row,
    input  julia_pkg::cfg_t             cfg,
    output logic                        res_valid,
    input  logic                        res_ready,
    output julia_pkg::result_t          res
);
    import julia_pkg::*;

    localparam int HALF_SIDE   = IMAGE_SIDE / 2;
    localparam int SIDE_W      = $clog2(IMAGE_SIDE + 1);
    localparam int ADDR_FULL_W = IDX_W + SIDE_W;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_START_X = 7'b0000010,
        S_START_Y = 7'b0000100,
        S_SQ_R    = 7'b0001000,
        S_SQ_I    = 7'b0010000,
        S_TEST    = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [COORD_W-1:0] zr_reg, zr_next;
    logic signed [COORD_W-1:0] zi_reg, zi_next;
    logic signed [SQ_W-1:0]    zr2_reg, zr2_next;
    logic signed [SQ_W-1:0]    zi2_reg, zi2_next;

    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [COORD_W-1:0] dist_col, dist_row, step_s;
    logic signed [COORD_W-1:0] prod_lo, cross_term, new_zr, new_zi;
    logic signed [SUM_W-1:0]   mag_sum;
    logic                      keep_going;
    logic [ADDR_FULL_W-1:0]    addr_full;
    logic [COLOR_W-1:0]        color;
    logic                      pixel_in_set;

    julia_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign dist_col = signed'(COORD_W'(col_reg)) - signed'(COORD_W'(HALF_SIDE));
    assign dist_row = signed'(COORD_W'(row_reg)) - signed'(COORD_W'(HALF_SIDE));
    assign step_s   = signed'({1'b0, cfg.pixel_step});

    // Low word wraps the start product; the cross term 2*zr*zi is the product shifted by 27.
    assign prod_lo    = mul_p[COORD_W-1:0];
    assign cross_term = mul_p[FRAC_BITS-2+COORD_W : FRAC_BITS-1];

    assign mag_sum    = SUM_W'(zr2_reg) + SUM_W'(zi2_reg);
    assign keep_going = (mag_sum < ESCAPE_BOUND) && (count_reg < cfg.iter_limit);
    assign new_zr     = zr2_reg[COORD_W-1:0] - zi2_reg[COORD_W-1:0] + cfg.c_real;
    assign new_zi     = cross_term + cfg.c_imag;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        zr2_next   = zr2_reg;
        zi2_next   = zi2_reg;
        mul_a      = zr_reg;
        mul_b      = zi_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = in_column;
                    row_next   = in_row;
                    count_next = '0;
                    state_next = S_START_X;
                end
            end
            S_START_X:
            begin
                mul_a      = dist_col;
                mul_b      = step_s;
                zr_next    = prod_lo + cfg.offset_x;
                state_next = S_START_Y;
            end
            S_START_Y:
            begin
                mul_a      = dist_row;
                mul_b      = step_s;
                zi_next    = prod_lo + cfg.offset_y;
                state_next = S_SQ_R;
            end
            S_SQ_R:
            begin
                mul_a      = zr_reg;
                mul_b      = zr_reg;
                zr2_next   = mul_p[PROD_W-1:FRAC_BITS];
                state_next = S_SQ_I;
            end
            S_SQ_I:
            begin
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                zi2_next   = mul_p[PROD_W-1:FRAC_BITS];
                state_next = S_TEST;
            end
            S_TEST:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
                if (keep_going)
                begin
                    zr_next    = new_zr;
                    zi_next    = new_zi;
                    count_next = count_reg + 1'b1;
                    state_next = S_SQ_R;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        row_reg <= row_next;
        zr_reg  <= zr_next;
        zi_reg  <= zi_next;
        zr2_reg <= zr2_next;
        zi2_reg <= zi2_next;
    end

    assign pixel_in_set = (count_reg == cfg.iter_limit);
    assign addr_full = ADDR_FULL_W'(row_reg) * ADDR_FULL_W'(IMAGE_SIDE) + ADDR_FULL_W'(col_reg);

    julia_color u_color
    (
        .iter_count    (count_reg),
        .in_set        (pixel_in_set),
        .color_factors (cfg.color_factors),
        .pixel_color   (color)
    );

    assign in_ready          = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res.pixel_address = ADDR_W'(addr_full);
    assign res.pixel_color   = color;
    assign res.iter_count    = count_reg;
    assign res.in_set        = pixel_in_set;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_START_X))
        else $error("accepted word did not start the start-point computation");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST && keep_going) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("iteration count did not advance on a continued iteration");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_TEST && !(in_valid && in_ready)) |=> $stable(count_reg))
        else $error("iteration count moved outside the escape test");

    a_black_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.in_set) |-> (res.pixel_color == '0))
        else $error("pixel in the set carries a colour");

endmodule

### hdl/julia_escape_time_pixel_top.sv
// Top level of the Julia escape-time pixel block: registers, core and output word register.
//
// Each input word names one pixel; the block computes its start point, iterates
// z = z^2 + c in signed Q4.28 until |z|^2 reaches 4 or the count reaches iter_limit,
// and returns one output word with the frame address, colour, count and in-set flag.
// All products go through one shared 32 by 32 multiplier, used three times per
// iteration (two squares, then the cross term alongside the escape test), and only
// one pixel is in flight at a time. A finished word waits in the output register,
// so the next pixel may be accepted before it is taken.
// Configuration is written through a plain write port and must only change while idle.
module julia_escape_time_pixel_top
#(
    parameter int IMAGE_SIDE = julia_pkg::DEF_IMAGE_SIDE
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_column [9:0], pixel_row [19:10], zero padding above
    input  logic [julia_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_address [19:0], pixel_color [43:20], iter_count [53:44], zero padding above
    output logic [julia_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // in_set [0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_wr_en,
    input  logic [julia_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [julia_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import julia_pkg::*;

    cfg_t    cfg_reg;
    result_t core_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    core_valid;
    logic    slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_C_REAL:        cfg_reg.c_real        <= signed'(cfg_data[COORD_W-1:0]);
                REG_C_IMAG:        cfg_reg.c_imag        <= signed'(cfg_data[COORD_W-1:0]);
                REG_PIXEL_STEP:    cfg_reg.pixel_step    <= cfg_data[STEP_W-1:0];
                REG_OFFSET_X:      cfg_reg.offset_x      <= signed'(cfg_data[COORD_W-1:0]);
                REG_OFFSET_Y:      cfg_reg.offset_y      <= signed'(cfg_data[COORD_W-1:0]);
                REG_ITER_LIMIT:    cfg_reg.iter_limit    <= cfg_data[CNT_W-1:0];
                REG_COLOR_FACTORS: cfg_reg.color_factors <= cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    julia_core #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_column (s_axis_tdata[IDX_W-1:0]),
        .in_row    (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .cfg       (cfg_reg),
        .res_valid (core_valid),
        .res_ready (slot_free),
        .res       (core_res)
    );

    // The output register takes a new word when empty or when its word leaves this cycle.
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && slot_free)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg.iter_count,
                            out_res_reg.pixel_color, out_res_reg.pixel_address};
    assign m_axis_tuser  = out_res_reg.in_set;

endmodule
